// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro is used on a line of its own with a label, clock, reset,
// antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tlsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlsr_pkg;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_POP     = 2'd1;
    localparam logic [1:0] KIND_PEEK    = 2'd2;
    localparam logic [1:0] KIND_REVERSE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Capacity register.
    localparam int         CAP_W     = 7;
    localparam logic [6:0] CAP_RESET = 7'd64;

    // One stored element: class bit over the raw data.
    typedef struct packed {
        logic        tag;
        logic [31:0] payload;
    } entry_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic        push_tag;
        logic [31:0] push_payload;
    } req_t;

    // One result item.
    typedef struct packed {
        logic        out_tag;
        logic [31:0] out_payload;
        logic [1:0]  status;
        logic        empty_res;
        logic [6:0]  count;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/tlsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tlsr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports; the data holds while no read is enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tagged_lifo_stack_with_reverse.sv
`timescale 1ns / 1ps
`default_nettype none

// LIFO stack of tagged 33-bit elements held in one synchronous RAM with a
// registered read. A push, and a pop or peek of an empty stack, is answered
// from idle; a pop or peek of a non-empty stack passes through S_READ, since
// the top entry comes out of the RAM in the cycle after its address is
// presented. A reverse swaps pairs from the ends inward through S_SWAP_LO and
// S_SWAP_HI on the single RAM write port, issuing both reads of the next pair
// in S_SWAP_LO. The next item is taken as soon as the block is back in its
// idle state and the result register is free or draining. The stack storage
// has no reset and needs no clearing pass; only entries below the count are ever used.
// The user must write capacity through the cfg port only while the block is
// idle; the block itself does not enforce it. Usable capacity saturates at DEPTH.
module tagged_lifo_stack_with_reverse #(
    parameter int DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire tlsr_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output tlsr_pkg::rsp_t     rsp,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [6:0]    cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_READ    = 2'd1;
    localparam logic [1:0] S_SWAP_LO = 2'd2;
    localparam logic [1:0] S_SWAP_HI = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    capacity_reg, capacity_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic          is_pop_reg, is_pop_next;
    logic          out_valid_reg, out_valid_next;
    tlsr_pkg::entry_t hold_reg, hold_next;
    tlsr_pkg::rsp_t   rsp_reg, rsp_new;

    logic             req_accept;
    logic             rsp_load;
    logic             full;
    logic             empty;
    logic [CW-1:0]    count_dec;
    logic [AW-1:0]    top_addr;
    logic [AW-1:0]    lo_inc;
    logic [AW-1:0]    hi_dec;
    logic [CW+6:0]    cnt_ext;
    logic [CW+6:0]    cap_ext;
    logic [CW+6:0]    res_ext;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    tlsr_pkg::entry_t ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr_a;
    logic [AW-1:0]    ram_raddr_b;
    tlsr_pkg::entry_t ram_rdata_a;
    tlsr_pkg::entry_t ram_rdata_b;

    // Element storage.
    tlsr_ram #(
        .WIDTH ($bits(tlsr_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // Handshakes. An item is taken only in idle with the result register
    // free by the next edge, so a result never waits for room.
    assign req_stall  = !((state_reg == S_IDLE) && (!out_valid_reg || !rsp_stall));
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = rsp_reg;
    assign cfg_ready  = 1'b1;

    // Stack status and addresses derived from the count.
    assign count_dec = count_reg - 1'b1;
    assign top_addr  = count_dec[AW-1:0];
    assign lo_inc    = lo_reg + 1'b1;
    assign hi_dec    = hi_reg - 1'b1;
    assign cnt_ext   = {7'b0, count_reg};
    assign cap_ext   = {{CW{1'b0}}, capacity_reg};
    assign full      = (cnt_ext >= cap_ext) || (count_reg >= DEPTH_C);
    assign empty     = (count_reg == '0);

    // Configuration write.
    assign capacity_next = (cfg_valid && cfg_ready) ? cfg_data : capacity_reg;

    // Operation sequencer. Only one RAM access pattern is live in any cycle,
    // and a write always lands at an edge before any later read of the same
    // entry, so no forwarding is needed.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        is_pop_next = is_pop_reg;
        hold_next   = hold_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = {req.push_tag, req.push_payload};
        ram_re      = 1'b0;
        ram_raddr_a = '0;
        ram_raddr_b = top_addr;
        rsp_load    = 1'b0;
        rsp_new     = '0;
        rsp_new.status = tlsr_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    ram_re = 1'b1;
                    case (req.kind)
                        tlsr_pkg::KIND_PUSH:
                        begin
                            rsp_load = 1'b1;
                            if (full)
                            begin
                                rsp_new.status = tlsr_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        tlsr_pkg::KIND_POP, tlsr_pkg::KIND_PEEK:
                        begin
                            if (empty)
                            begin
                                rsp_load       = 1'b1;
                                rsp_new.status = tlsr_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                is_pop_next = (req.kind == tlsr_pkg::KIND_POP);
                                state_next  = S_READ;
                            end
                        end
                        tlsr_pkg::KIND_REVERSE:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = top_addr;
                                state_next = S_SWAP_LO;
                            end
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp_new.out_tag     = ram_rdata_b.tag;
                rsp_new.out_payload = ram_rdata_b.payload;
                if (is_pop_reg)
                begin
                    count_next = count_dec;
                end
                rsp_load   = 1'b1;
                state_next = S_IDLE;
            end
            S_SWAP_LO:
            begin
                // Upper entry goes low; keep the lower one and fetch the next pair.
                ram_we      = 1'b1;
                ram_waddr   = lo_reg;
                ram_wdata   = ram_rdata_b;
                hold_next   = ram_rdata_a;
                ram_re      = 1'b1;
                ram_raddr_a = lo_inc;
                ram_raddr_b = hi_dec;
                state_next  = S_SWAP_HI;
            end
            S_SWAP_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = hold_reg;
                lo_next   = lo_inc;
                hi_next   = hi_dec;
                if (lo_inc < hi_dec)
                begin
                    state_next = S_SWAP_LO;
                end
                else
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_ext           = {7'b0, count_next};
        rsp_new.empty_res = (count_next == '0);
        rsp_new.count     = res_ext[6:0];
    end

    // Result register valid flag.
    assign out_valid_next = rsp_load || (out_valid_reg && rsp_stall);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            capacity_reg  <= tlsr_pkg::CAP_RESET;
            lo_reg        <= '0;
            hi_reg        <= '0;
            is_pop_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            capacity_reg  <= capacity_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            is_pop_reg    <= is_pop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_new;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tlsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tlsr_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire tlsr_pkg::rsp_t rsp
);

    // A stalled result item stays put.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result item changed while stalled")

    // An input item is only taken while no result item is held up.
    `ASSERT_SAME(a_take_free, clk, rst_n, req_valid && !req_stall, !(rsp_valid && rsp_stall), "input item taken while a result item waits")

    // Underflow only happens on an empty stack and carries no element.
    `ASSERT_SAME(a_underflow, clk, rst_n, rsp_valid && (rsp.status == tlsr_pkg::ST_UNDERFLOW), rsp.empty_res && (rsp.count == 7'd0) && !rsp.out_tag && (rsp.out_payload == 32'd0), "underflow result is not empty")

    // A dropped push carries no element.
    `ASSERT_SAME(a_overflow, clk, rst_n, rsp_valid && (rsp.status == tlsr_pkg::ST_OVERFLOW), !rsp.out_tag && (rsp.out_payload == 32'd0), "overflow result carries data")

    // An empty result always reports a zero count.
    `ASSERT_SAME(a_empty_count, clk, rst_n, rsp_valid && rsp.empty_res, rsp.count == 7'd0, "empty result with nonzero count")

endmodule

bind tagged_lifo_stack_with_reverse tlsr_checker u_tlsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
